[rtl/mt_rng_pkg.sv]
// Shared types, constants and helper functions for the Mersenne Twister generator.
package mt_rng_pkg;

  // Table geometry
  localparam int TABLE_DEPTH  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);

  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_OFFSET  = IDX_W'(TWIST_OFFSET);
  localparam logic [IDX_W-1:0] IDX_WRAPGAP = IDX_W'(TABLE_DEPTH - TWIST_OFFSET);

  // Recurrence and tempering constants
  localparam logic [31:0] INIT_MULT  = 32'h6C07_8965;
  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] MATRIX_A   = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;
  localparam logic [31:0] SEED_RESET = 32'd5489;

  // Remainder unit: one quotient bit per cycle
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // Request modes
  localparam logic [1:0] FUNC_RAW   = 2'd0;
  localparam logic [1:0] FUNC_MOD   = 2'd1;
  localparam logic [1:0] FUNC_RANGE = 2'd2;

  // Table read address selection
  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_NEXT = 2'd1,
    RD_FAR  = 2'd2
  } rd_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    seed_wr;
    logic    fill_start;
    logic    fill_mul;
    logic    fill_wr;
    logic    in_load;
    rd_sel_t rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    twist_wr;
    logic    temper;
    logic    div_init;
    logic    div_step;
    logic    res_special;
    logic    res_raw;
    logic    res_div;
    logic    out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] func;
    logic       bound_zero;
    logic       bounds_equal;
    logic       span_zero;
    logic       fill_last;
  } dp_status_t;

  // Output tempering of one table word
  function automatic logic [31:0] mt_temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[rtl/mt_rng_dp.sv]
// Datapath of the generator: state table memory, seeding multiplier, twist, tempering and remainder unit.
module mt_rng_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  mt_rng_pkg::dp_cmd_t   cmd,
  output mt_rng_pkg::dp_status_t status,
  input  logic [31:0]           cfg_data,
  input  logic [1:0]            in_func,
  input  logic [31:0]           in_first,
  input  logic [31:0]           in_second,
  output logic [31:0]           out_value
);
  import mt_rng_pkg::*;

  // State table memory
  logic [31:0]      mem [TABLE_DEPTH];
  logic [31:0]      rdata;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;
  logic             we;

  // Configuration and request registers
  logic [31:0]      seed;
  logic [1:0]       func_r;
  logic [31:0]      a_r;
  logic [31:0]      b_r;
  logic [31:0]      lo_r;
  logic [31:0]      span_r;

  // Seeding
  logic [IDX_W-1:0] fill_i;
  logic [31:0]      fill_p;
  logic [31:0]      fill_prod;
  logic [31:0]      fill_val;

  // Draw path
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next1;
  logic [IDX_W-1:0] idx_far;
  logic [31:0]      word_a;
  logic [31:0]      word_b;
  logic [31:0]      twist_y;
  logic [31:0]      twist_val;
  logic [31:0]      raw;
  logic [31:0]      rand_word;

  // Remainder unit
  logic [31:0]      divisor;
  logic [31:0]      rem;
  logic [31:0]      quo;
  logic [32:0]      trial;
  logic [32:0]      trial_diff;

  // Result and output word
  logic [31:0]      res;
  logic [31:0]      out_word;

  // Seed register, the one configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cmd.seed_wr) begin
      seed <= cfg_data;
    end
  end

  // Neighbour addresses of the entry being twisted
  assign idx_next1 = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
  assign idx_far   = (idx < IDX_WRAPGAP) ? idx + IDX_OFFSET : idx - IDX_WRAPGAP;

  // Read address selection
  always_comb begin
    unique case (cmd.rd_sel)
      RD_IDX:  raddr = idx;
      RD_NEXT: raddr = idx_next1;
      RD_FAR:  raddr = idx_far;
      default: raddr = idx;
    endcase
  end

  // Seeding recurrence step and twist of one entry
  assign fill_val  = fill_prod + {{(32-IDX_W){1'b0}}, fill_i};
  assign twist_y   = (word_a & UPPER_MASK) | (word_b & LOWER_MASK);
  assign twist_val = rdata ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : 32'd0);

  // Write port selection
  always_comb begin
    we    = cmd.fill_start | cmd.fill_wr | cmd.twist_wr;
    waddr = idx;
    wdata = twist_val;
    if (cmd.fill_start) begin
      waddr = '0;
      wdata = seed;
    end else if (cmd.fill_wr) begin
      waddr = fill_i;
      wdata = fill_val;
    end
  end

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Seeding counters and multiplier, with a single product register shared by all entries
  always_ff @(posedge clk) begin
    if (cmd.fill_start) begin
      fill_p <= seed;
      fill_i <= IDX_W'(1);
    end else if (cmd.fill_wr) begin
      fill_p <= fill_val;
      fill_i <= fill_i + IDX_W'(1);
    end
    if (cmd.fill_mul) begin
      fill_prod <= INIT_MULT * (fill_p ^ (fill_p >> 30));
    end
  end

  // Draw index restarts at the first entry after every seeding
  always_ff @(posedge clk) begin
    if (rst || cmd.fill_start) begin
      idx <= '0;
    end else if (cmd.twist_wr) begin
      idx <= idx_next1;
    end
  end

  // Request capture and range preparation
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      func_r <= in_func;
      a_r    <= in_first;
      b_r    <= in_second;
    end
    lo_r   <= (a_r < b_r) ? a_r : b_r;
    span_r <= ((a_r < b_r) ? b_r - a_r : a_r - b_r) + 32'd1;
  end

  // Operand capture, twist result and tempering
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      word_a <= rdata;
    end
    if (cmd.cap_b) begin
      word_b <= rdata;
    end
    if (cmd.twist_wr) begin
      raw <= twist_val;
    end
    if (cmd.temper) begin
      rand_word <= mt_temper(raw);
    end
  end

  // Restoring remainder, one bit per step
  assign divisor    = (func_r == FUNC_MOD) ? a_r : span_r;
  assign trial      = {rem, quo[31]};
  assign trial_diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      quo <= rand_word;
    end else if (cmd.div_step) begin
      quo <= {quo[30:0], 1'b0};
      rem <= trial_diff[32] ? trial[31:0] : trial_diff[31:0];
    end
  end

  // Result selection and output word
  always_ff @(posedge clk) begin
    if (cmd.res_special) begin
      res <= (func_r == FUNC_RANGE) ? a_r : 32'd0;
    end else if (cmd.res_raw) begin
      res <= rand_word;
    end else if (cmd.res_div) begin
      res <= rem + ((func_r == FUNC_RANGE) ? lo_r : 32'd0);
    end
    if (cmd.out_load) begin
      out_word <= res;
    end
  end

  assign out_value = out_word;

  // Status back to the controller
  assign status.func         = func_r;
  assign status.bound_zero   = (a_r == 32'd0);
  assign status.bounds_equal = (a_r == b_r);
  assign status.span_zero    = (func_r == FUNC_RANGE) && (span_r == 32'd0);
  assign status.fill_last    = (fill_i == IDX_LAST);

endmodule

[rtl/mt_rng_ctrl.sv]
// Controller of the generator: sequences seeding, draws, remainder steps and the output handshake.
module mt_rng_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  mt_rng_pkg::dp_status_t status,
  output mt_rng_pkg::dp_cmd_t    cmd
);
  import mt_rng_pkg::*;

  typedef enum logic [13:0] {
    S_FILL0    = 14'b00000000000001,
    S_FILL_MUL = 14'b00000000000010,
    S_FILL_WR  = 14'b00000000000100,
    S_IDLE     = 14'b00000000001000,
    S_DECODE   = 14'b00000000010000,
    S_RD_A     = 14'b00000000100000,
    S_RD_B     = 14'b00000001000000,
    S_RD_C     = 14'b00000010000000,
    S_TWIST    = 14'b00000100000000,
    S_TEMPER   = 14'b00001000000000,
    S_POST     = 14'b00010000000000,
    S_DIV      = 14'b00100000000000,
    S_ADD      = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 out_valid;
  logic                 cfg_acc;
  logic                 in_acc;

  // Handshakes: seeding restarts on a write, requests only when idle
  assign cfg_ready = (state == S_FILL0) || (state == S_FILL_MUL) ||
                     (state == S_FILL_WR) || (state == S_IDLE);
  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_IDX;
    cmd.seed_wr = cfg_acc;
    unique case (state)
      S_FILL0: begin
        cmd.fill_start = 1'b1;
        state_next     = S_FILL_MUL;
      end
      S_FILL_MUL: begin
        cmd.fill_mul = 1'b1;
        state_next   = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.fill_wr = 1'b1;
        state_next  = status.fill_last ? S_IDLE : S_FILL_MUL;
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd.in_load = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.func)
          FUNC_RAW: state_next = S_RD_A;
          FUNC_MOD: state_next = status.bound_zero ? S_FIN : S_RD_A;
          FUNC_RANGE: state_next = status.bounds_equal ? S_FIN : S_RD_A;
          default: state_next = S_FIN;
        endcase
        cmd.res_special = (state_next == S_FIN);
      end
      S_RD_A: begin
        cmd.rd_sel = RD_IDX;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_sel = RD_NEXT;
        cmd.cap_a  = 1'b1;
        state_next = S_RD_C;
      end
      S_RD_C: begin
        cmd.rd_sel = RD_FAR;
        cmd.cap_b  = 1'b1;
        state_next = S_TWIST;
      end
      S_TWIST: begin
        cmd.twist_wr = 1'b1;
        state_next   = S_TEMPER;
      end
      S_TEMPER: begin
        cmd.temper = 1'b1;
        state_next = S_POST;
      end
      S_POST: begin
        if ((status.func == FUNC_RAW) || status.span_zero) begin
          cmd.res_raw = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIV_CNT_LAST) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.res_div = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_FILL0;
    endcase
    if (cfg_acc) begin
      state_next = S_FILL0;
    end
  end

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_init) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A seed write always restarts the table fill
  a_cfg_restarts_fill: assert property (@(posedge clk) disable iff (rst)
    cfg_acc |=> (state == S_FILL0))
    else $error("seed write did not restart the table fill");

  // An accepted request is decoded in the next cycle
  a_req_decoded: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_DECODE))
    else $error("accepted request was not decoded");

  // The remainder unit runs its full number of steps
  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == DIV_CNT_LAST) |=> (state == S_ADD))
    else $error("remainder unit left early or late");

  // A pending word is never overwritten by a finished result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !m_tready) |=> (state == S_FIN && out_valid))
    else $error("finished result overwrote a word not yet taken");

endmodule

[rtl/mersenne_twister_rng.sv]
// Top level of the MT19937 generator: stream channels, seed write channel, controller and datapath.
//
// Usage: a request word enters on the s_ channel (mode in s_tuser, the two bounds in
// s_tdata) and one result word leaves on the m_ channel for every request. The seed
// register is written on the cfg_ channel; each write refills the 624-entry state table
// and the next draw starts the freshly twisted table from its first entry.
// Requests are taken one at a time; s_tready is high only while the block is idle.
// From acceptance to m_tvalid, a request that draws nothing (zero bound, equal range
// ends, unused mode) passes S_DECODE and S_FIN; a raw word or a full-range draw also
// passes the three reads of the single table port, the twist of one entry per draw and
// the tempering, and a reduced draw also the 32-step remainder unit and its final add.
// With a ready receiver the next request can be taken in the cycle after the result is
// loaded; a new request is never taken while the last one is still in work.
// After reset, and after every seed write, the seed fills the first entry and one
// multiplier step fills each further entry; no request is taken during the fill.
// The result sits in an output register; a stalled receiver does not stop the next
// request being accepted, and a finished result waits until the pending word is taken.
module mersenne_twister_rng (
  input  logic        clk,
  input  logic        rst,
  // Seed write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,   // seed
  // Request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,    // first_bound [31:0], second_bound [63:32]
  input  logic [1:0]  s_tuser,    // func [1:0]
  // Result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata     // value [31:0]
);
  import mt_rng_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing
  mt_rng_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Table, arithmetic and result word
  mt_rng_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_data  (cfg_data),
    .in_func   (s_tuser),
    .in_first  (s_tdata[31:0]),
    .in_second (s_tdata[63:32]),
    .out_value (m_tdata)
  );

endmodule

[verif/tb_mersenne_twister_rng.sv]
// Self-checking testbench for mersenne_twister_rng: predicted MT19937 draws compared with the result stream.
module tb_mersenne_twister_rng;
  import mt_rng_pkg::*;

  // Generator geometry and constants, kept apart from the RTL package on purpose
  localparam int          MT_N           = 624;
  localparam int          MT_M           = 397;
  localparam logic [31:0] MT_INIT_MULT   = 32'h6C07_8965;
  localparam logic [31:0] MT_UPPER       = 32'h8000_0000;
  localparam logic [31:0] MT_LOWER       = 32'h7FFF_FFFF;
  localparam logic [31:0] MT_MATRIX      = 32'h9908_B0DF;
  localparam logic [31:0] MT_TEMPER_B    = 32'h9D2C_5680;
  localparam logic [31:0] MT_TEMPER_C    = 32'hEFC6_0000;
  localparam logic [31:0] SEED_AT_RESET  = 32'd5489;
  localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
  localparam int          QUIET_LIMIT    = 8000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          SHOWN_ERRORS   = 10;

  // Predicts every result word from the requests in the order they were accepted.
  class mt_draw_tracker;
    logic [31:0] words [MT_N];
    int unsigned next_pos;
    logic [31:0] expected_values [$];
    int unsigned failures, results_seen, words_drawn;
    int unsigned n_raw, n_mod, n_range, n_unused, n_zero_bound, n_equal, n_full;

    function new();
      reseed(SEED_AT_RESET);
    endfunction

    // A seed write refills the table and forces a twist on the next draw.
    function void reseed(logic [31:0] seed_value);
      int i;
      words[0] = seed_value;
      for (i = 1; i < MT_N; i++)
        words[i] = MT_INIT_MULT * (words[i-1] ^ (words[i-1] >> 30)) + 32'(i);
      next_pos = MT_N;
    endfunction

    function logic [31:0] next_word();
      logic [31:0] y, nv;
      int i;
      // Twist the whole table once every entry has been used
      if (next_pos >= MT_N) begin
        for (i = 0; i < MT_N; i++) begin
          y  = (words[i] & MT_UPPER) | (words[(i + 1) % MT_N] & MT_LOWER);
          nv = words[(i + MT_M) % MT_N] ^ (y >> 1);
          if (y[0])
            nv = nv ^ MT_MATRIX;
          words[i] = nv;
        end
        next_pos = 0;
      end
      y = words[next_pos];
      next_pos++;
      words_drawn++;
      // Tempering
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & MT_TEMPER_B);
      y = y ^ ((y << 15) & MT_TEMPER_C);
      y = y ^ (y >> 18);
      return y;
    endfunction

    function void note_request(logic [1:0] func, logic [31:0] first_b, logic [31:0] second_b);
      logic [31:0] v, lo, hi, span;
      v = '0;
      case (func)
        FUNC_RAW: begin
          n_raw++;
          v = next_word();
        end
        FUNC_MOD: begin
          n_mod++;
          if (first_b == 32'd0)
            n_zero_bound++;
          else
            v = next_word() % first_b;
        end
        FUNC_RANGE: begin
          n_range++;
          if (first_b == second_b) begin
            n_equal++;
            v = first_b;
          end else begin
            lo   = (first_b < second_b) ? first_b : second_b;
            hi   = (first_b < second_b) ? second_b : first_b;
            span = hi - lo + 32'd1;
            v    = next_word();
            if (span == 32'd0)
              n_full++;
            else
              v = v % span + lo;
          end
        end
        default: n_unused++;
      endcase
      expected_values.push_back(v);
    endfunction

    function void check_value(logic [31:0] got);
      logic [31:0] want;
      results_seen++;
      if (expected_values.size() == 0) begin
        failures++;
        if (failures <= SHOWN_ERRORS)
          $display("Unexpected result word %h with nothing outstanding", got);
      end else begin
        want = expected_values.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= SHOWN_ERRORS)
            $display("Result %0d: value expected %h, got %h", results_seen, want, got);
        end
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // first_bound [31:0], second_bound [63:32]
  logic [1:0]  s_tuser = '0;   // func [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // value [31:0]

  mt_draw_tracker book = new();
  int unsigned    burst_left = 0;
  bit             gapless = 1'b0;
  int unsigned    seeds_written = 0;
  int unsigned    quiet_cycles = 0;

  mersenne_twister_rng dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Clock: period of 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one request word, with a random gap at the start of some bursts, none while gapless is set.
  task automatic send_request(input logic [1:0] func, input logic [31:0] first_b,
                              input logic [31:0] second_b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = 0;
      if (!gapless && $urandom_range(0, 2) != 0)
        gap = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {second_b, first_b};
    do @(posedge clk); while (s_tready !== 1'b1);
    book.note_request(func, first_b, second_b);
  endtask

  // Drains the block, then writes a new seed.
  task automatic reseed_when_idle(input logic [31:0] new_seed);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= new_seed;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    book.reseed(new_seed);
    seeds_written++;
    @(negedge clk);
    cfg_valid  <= 1'b0;
    burst_left = 0;
  endtask

  // Mostly small or extreme bounds, with fully random ones mixed in.
  function automatic logic [31:0] pick_end();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(1, 12));
      3:       return 32'($urandom_range(1, 1000));
      4:       return 32'h8000_0000 | $urandom();
      default: return $urandom();
    endcase
  endfunction

  // Receiver: randomly changing stall patterns, with long hold-offs.
  initial begin : result_sink
    int unsigned hold_left, mode_left, next_hold, mode;
    hold_left = 0;
    mode_left = 0;
    next_hold = 300;
    mode      = 0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_left == 0 && book.results_seen >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = next_hold + 700;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 0);
          2:       m_tready <= ($urandom_range(0, 4) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      @(posedge clk);
      if (m_tvalid && m_tready)
        book.check_value(m_tdata);
      @(negedge clk);
    end
  end

  // Watchdog: ends the run when no channel has moved a word for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, book.pending());
        $display("FAIL mersenne_twister_rng");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [31:0] phase_seeds [6];
    int unsigned phase_items [6];
    logic [1:0]  func;
    logic [31:0] a, b;
    int unsigned r;
    int          phase, n;

    phase_seeds = '{$urandom(), 32'h0, 32'hFFFF_FFFF, 32'd1, $urandom(), SEED_AT_RESET};
    phase_items = '{900, 110, 110, 110, 110, 110};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests on the reset seed
    send_request(FUNC_RAW,    32'h0,         32'h0);
    send_request(FUNC_RAW,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(FUNC_MOD,    32'h0,         32'hFFFF_FFFF);
    send_request(FUNC_MOD,    32'd1,         32'h0);
    send_request(FUNC_MOD,    32'hFFFF_FFFF, 32'h0);
    send_request(FUNC_MOD,    32'h8000_0000, 32'h0);
    send_request(FUNC_MOD,    32'd7,         32'h0);
    send_request(FUNC_RANGE,  32'd5,         32'd5);
    send_request(FUNC_RANGE,  32'h0,         32'h0);
    send_request(FUNC_RANGE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(FUNC_RANGE,  32'h0,         32'hFFFF_FFFF);
    send_request(FUNC_RANGE,  32'hFFFF_FFFF, 32'h0);
    send_request(FUNC_RANGE,  32'd100,       32'd10);
    send_request(FUNC_RANGE,  32'd10,        32'd100);
    send_request(FUNC_RANGE,  32'h0,         32'd1);
    send_request(FUNC_RANGE,  32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(FUNC_RANGE,  32'h7FFF_FFFF, 32'h8000_0000);
    send_request(FUNC_UNUSED, 32'h0,         32'h0);
    send_request(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(FUNC_UNUSED, $urandom(),    $urandom());
    send_request(FUNC_RAW,    32'h0,         32'h0);

    // Random phases, each on a fresh seed; the first runs past a table twist
    for (phase = 0; phase < 6; phase++) begin
      reseed_when_idle(phase_seeds[phase]);
      gapless = (phase == 2 || phase == 4);
      for (n = 0; n < phase_items[phase]; n++) begin
        r = $urandom_range(0, 19);
        a = pick_end();
        b = $urandom();
        if (r < 6) begin
          func = FUNC_RAW;
        end else if (r < 12) begin
          func = FUNC_MOD;
        end else if (r < 18) begin
          func = FUNC_RANGE;
          case ($urandom_range(0, 9))
            0:       b = a;
            1:       begin a = 32'h0; b = 32'hFFFF_FFFF; end
            2:       b = a + 32'($urandom_range(1, 20));
            default: b = pick_end();
          endcase
        end else begin
          func = FUNC_UNUSED;
        end
        send_request(func, a, b);
      end
    end

    // Drain and allow for any stray late result
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Checked %0d results from %0d raw, %0d bounded, %0d range and %0d unused requests",
             book.results_seen, book.n_raw, book.n_mod, book.n_range, book.n_unused);
    $display("%0d seeds written, %0d words drawn; %0d zero bounds, %0d equal ends, %0d full spans",
             seeds_written, book.words_drawn, book.n_zero_bound, book.n_equal, book.n_full);
    if (book.failures == 0 && book.pending() == 0)
      $display("PASS mersenne_twister_rng");
    else
      $display("FAIL mersenne_twister_rng");
    $finish;
  end

endmodule

[mersenne_twister_rng.f]
rtl/mt_rng_pkg.sv
rtl/mt_rng_dp.sv
rtl/mt_rng_ctrl.sv
rtl/mersenne_twister_rng.sv
verif/tb_mersenne_twister_rng.sv
